// File: rtl/hdp_pkg.sv
// Shared types, constants and decode functions of the Hamming(24,16) packet decoder.
`default_nettype none

package hdp_pkg;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_PARITY = 2'd2;

    localparam logic [3:0] SYN_UNCORR_LO = 4'd13;
    localparam logic [7:0] BYTE_ERASED   = 8'hFF;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] ERR_MAX       = 8'hFF;

    localparam logic [3:0] PARITY_CODE [8] = '{
        4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12
    };

    localparam logic [7:0] FLIP_MASK [16] = '{
        8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h04, 8'h08,
        8'h00, 8'h10, 8'h20, 8'h40, 8'h80, 8'h00, 8'h00, 8'h00
    };

    // One entry of the command queue: every result that one accepted beat causes.
    typedef struct packed {
        logic       pend_en;
        logic [7:0] pend_byte;
        logic       a_en;
        logic [7:0] a_byte;
        logic       eop;
        logic       fin_valid;
        logic [7:0] fin_byte;
        logic [7:0] fin_err;
    } t_cmd;

    function automatic logic [3:0] parity_of(input logic [7:0] d);
        logic [3:0] p;
        p = 4'd0;
        for (int b = 0; b < 8; b++) begin
            if (d[b]) begin
                p = p ^ PARITY_CODE[b];
            end
        end
        return p;
    endfunction

    function automatic logic [7:0] flip_of(input logic [3:0] syn);
        return FLIP_MASK[syn];
    endfunction

    function automatic logic uncorrectable(input logic [3:0] syn);
        return syn >= SYN_UNCORR_LO;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hdp_front.sv
// Front end: accepts packet bytes, decodes each group and queues its results.
`default_nettype none

module hdp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_end_of_packet,
    input  wire logic          i_q_full,
    output logic               o_full,
    output logic               o_cmd_push,
    output hdp_pkg::t_cmd      o_cmd
);

    logic [1:0] r_pos, n_pos;
    logic [7:0] r_held_first, n_held_first;
    logic [7:0] r_held_second, n_held_second;
    logic [7:0] r_pend_byte, n_pend_byte;
    logic       r_pend_valid, n_pend_valid;
    logic [7:0] r_err, n_err;

    logic       accept;
    logic       complete;
    logic [7:0] syn;
    logic [7:0] a_corr;
    logic [7:0] b_corr;
    logic [1:0] errs;
    logic [8:0] err_sum;
    logic [7:0] err_sat;
    logic       grp_pend_valid;
    logic [7:0] grp_pend_byte;
    logic [7:0] grp_err;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign complete = (r_pos == hdp_pkg::POS_PARITY);

    always_comb begin
        syn = {hdp_pkg::parity_of(r_held_second), hdp_pkg::parity_of(r_held_first)}
              ^ i_rx_byte;
        a_corr = r_held_first;
        b_corr = r_held_second;
        errs   = 2'd0;
        if (hdp_pkg::uncorrectable(syn[3:0])) begin
            errs = errs + 2'd1;
        end else begin
            a_corr = r_held_first ^ hdp_pkg::flip_of(syn[3:0]);
        end
        if (hdp_pkg::uncorrectable(syn[7:4])) begin
            errs = errs + 2'd1;
        end else begin
            b_corr = r_held_second ^ hdp_pkg::flip_of(syn[7:4]);
        end
        err_sum = {1'b0, r_err} + {7'd0, errs};
        err_sat = err_sum[8] ? hdp_pkg::ERR_MAX : err_sum[7:0];
    end

    always_comb begin
        grp_pend_valid = complete ? 1'b1 : r_pend_valid;
        grp_pend_byte  = complete ? b_corr : r_pend_byte;
        grp_err        = complete ? err_sat : r_err;

        o_cmd.pend_en   = complete && r_pend_valid;
        o_cmd.pend_byte = r_pend_byte;
        o_cmd.a_en      = complete;
        o_cmd.a_byte    = a_corr;
        o_cmd.eop       = i_end_of_packet;
        o_cmd.fin_valid = grp_pend_valid;
        o_cmd.fin_byte  = (!grp_pend_valid || grp_pend_byte == hdp_pkg::BYTE_ERASED)
                          ? hdp_pkg::BYTE_ZERO : grp_pend_byte;
        o_cmd.fin_err   = grp_err;
        o_cmd_push      = accept && (complete || i_end_of_packet);
    end

    always_comb begin
        n_pos         = r_pos;
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        n_pend_byte   = r_pend_byte;
        n_pend_valid  = r_pend_valid;
        n_err         = r_err;
        if (accept) begin
            case (r_pos)
                hdp_pkg::POS_FIRST: begin
                    n_held_first = i_rx_byte;
                    n_pos        = hdp_pkg::POS_SECOND;
                end
                hdp_pkg::POS_SECOND: begin
                    n_held_second = i_rx_byte;
                    n_pos         = hdp_pkg::POS_PARITY;
                end
                default: begin
                    n_pend_byte  = grp_pend_byte;
                    n_pend_valid = grp_pend_valid;
                    n_err        = grp_err;
                    n_pos        = hdp_pkg::POS_FIRST;
                end
            endcase
            if (i_end_of_packet) begin
                n_pos         = hdp_pkg::POS_FIRST;
                n_held_first  = 8'd0;
                n_held_second = 8'd0;
                n_pend_byte   = 8'd0;
                n_pend_valid  = 1'b0;
                n_err         = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= hdp_pkg::POS_FIRST;
            r_held_first  <= 8'd0;
            r_held_second <= 8'd0;
            r_pend_byte   <= 8'd0;
            r_pend_valid  <= 1'b0;
            r_err         <= 8'd0;
        end else begin
            r_pos         <= n_pos;
            r_held_first  <= n_held_first;
            r_held_second <= n_held_second;
            r_pend_byte   <= n_pend_byte;
            r_pend_valid  <= n_pend_valid;
            r_err         <= n_err;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hdp_cmdq.sv
// Short command queue between the decoding front end and the result back end.
`default_nettype none

module hdp_cmdq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  hdp_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output hdp_pkg::t_cmd      o_cmd
);

    hdp_pkg::t_cmd r_mem [hdp_pkg::CMDQ_DEPTH];

    logic [hdp_pkg::CMDQ_AW-1:0] r_wr, n_wr;
    logic [hdp_pkg::CMDQ_AW-1:0] r_rd, n_rd;
    logic [hdp_pkg::CMDQ_AW:0]   r_cnt, n_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_cnt == (hdp_pkg::CMDQ_AW+1)'(hdp_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hdp_back.sv
// Back end: expands queued commands into result beats held in an output register.
`default_nettype none

module hdp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  hdp_pkg::t_cmd      i_cmd,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_data_byte,
    output logic               o_data_valid,
    output logic               o_last,
    output logic [7:0]         o_error_count
);

    logic       r_out_valid, n_out_valid;
    logic [2:0] r_done, n_done;
    logic [7:0] r_data_byte, n_data_byte;
    logic       r_data_valid, n_data_valid;
    logic       r_last, n_last;
    logic [7:0] r_error_count, n_error_count;

    logic rem_p, rem_a, rem_e;
    logic sel_p, sel_a, sel_e;
    logic more;
    logic load;

    always_comb begin
        rem_p = i_cmd.pend_en && !r_done[0];
        rem_a = i_cmd.a_en && !r_done[1];
        rem_e = i_cmd.eop && !r_done[2];
        sel_p = rem_p;
        sel_a = !rem_p && rem_a;
        sel_e = !rem_p && !rem_a && rem_e;
        more  = (sel_p && (rem_a || rem_e)) || (sel_a && rem_e);
        load  = !i_q_empty && (!r_out_valid || i_pop);

        o_q_pop = load && !more;

        n_out_valid   = r_out_valid;
        n_done        = r_done;
        n_data_byte   = r_data_byte;
        n_data_valid  = r_data_valid;
        n_last        = r_last;
        n_error_count = r_error_count;
        if (load) begin
            n_out_valid = 1'b1;
            n_done      = more ? (r_done | {sel_e, sel_a, sel_p}) : 3'd0;
            if (sel_p) begin
                n_data_byte = i_cmd.pend_byte;
            end else if (sel_a) begin
                n_data_byte = i_cmd.a_byte;
            end else begin
                n_data_byte = i_cmd.fin_byte;
            end
            n_data_valid  = sel_e ? i_cmd.fin_valid : 1'b1;
            n_last        = sel_e;
            n_error_count = sel_e ? i_cmd.fin_err : 8'd0;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= 3'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_done      <= n_done;
        end
        r_data_byte   <= n_data_byte;
        r_data_valid  <= n_data_valid;
        r_last        <= n_last;
        r_error_count <= n_error_count;
    end

    assign o_empty       = !r_out_valid;
    assign o_data_byte   = r_data_byte;
    assign o_data_valid  = r_data_valid;
    assign o_last        = r_last;
    assign o_error_count = r_error_count;

endmodule

`default_nettype wire

// File: rtl/hamming_24_16_packet_decoder_top.sv
// Usage: packet bytes are pushed in while full is low, one beat per cycle. Every
// group of three bytes (data A, data B, parity) is checked and single-bit errors
// are corrected. A group's parity byte yields the held-back B of the previous
// group, if any, and then the corrected A. The beat marked end_of_packet yields
// one final beat with last set, carrying the held-back B (0xFF read as 0x00)
// and the count of uncorrectable nibbles, which saturates at 255.
// Results are read like a queue: a beat waits on the outputs while empty is low
// and leaves on pop. A result passes the command queue and output register before
// it is visible. Input takes one beat per cycle while full is low; output gives
// one per cycle while pop is high, so a beat's up to three results leave in turn.
// A four-entry command queue sits between decoding and output; when the reader
// stalls it fills and full rises, holding the sender back. Synchronous reset
// empties the queue and output register and clears the group state.
`default_nettype none

module hamming_24_16_packet_decoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_end_of_packet,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_data_byte,
    output logic            o_data_valid,
    output logic            o_last,
    output logic [7:0]      o_error_count
);

    hdp_pkg::t_cmd front_cmd;
    hdp_pkg::t_cmd head_cmd;
    logic          cmd_push;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    hdp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_rx_byte       (i_rx_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_q_full        (q_full),
        .o_full          (full),
        .o_cmd_push      (cmd_push),
        .o_cmd           (front_cmd)
    );

    hdp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    hdp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (head_cmd),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_data_byte   (o_data_byte),
        .o_data_valid  (o_data_valid),
        .o_last        (o_last),
        .o_error_count (o_error_count)
    );

    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !q_full)
        else $error("Command pushed into a full queue.");

    a_count_only_on_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> (o_error_count == 8'd0 && o_data_valid))
        else $error("Non-final beat carries an error count or no data.");

    a_invalid_is_final_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data_valid) |-> (o_last && o_data_byte == 8'd0))
        else $error("Beat without data is not a cleared final beat.");

    a_pop_needs_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("Command popped from an empty queue.");

endmodule

`default_nettype wire
